>>> rtl/mlff_pkg.sv
// mlff_pkg: shared types and codes for the mesh link frame filter
// no dependencies; imported by the top level unit and the bench
package mlff_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEVAL,
    ST_TSCAN,
    ST_TEMIT,
    ST_THB,
    ST_SEARCH,
    ST_INSERT,
    ST_ELECT,
    ST_EAPPLY,
    ST_FEMIT
  } state_t;

  typedef enum logic [1:0] {
    NODE_UNASSIGNED = 2'd0,
    NODE_HOST       = 2'd1,
    NODE_CLIENT     = 2'd2
  } role_t;

  // result kinds
  localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
  localparam logic [2:0] KIND_COMMAND   = 3'd1;
  localparam logic [2:0] KIND_DUPLICATE = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd4;
  localparam logic [2:0] KIND_HB_DUE    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_MY_ID      = 3'd0;
  localparam logic [2:0] REG_TIMEOUT    = 3'd1;
  localparam logic [2:0] REG_HB_PERIOD  = 3'd2;
  localparam logic [2:0] REG_HB_TAG     = 3'd3;
  localparam logic [2:0] REG_CMD_TAG    = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd3000;
  localparam logic [15:0] HB_PERIOD_RESET = 16'd1000;
  localparam logic [7:0]  HB_TAG_RESET    = 8'd0;
  localparam logic [7:0]  CMD_TAG_RESET   = 8'd1;
  localparam logic [8:0]  HEADER_BYTES    = 9'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  event_side;
    logic [31:0] sender_id;
    logic [15:0] frame_seq;
    logic [7:0]  payload_len;
    logic [5:0]  forward_mask;
    logic        newly_connected;
    logic [1:0]  role;
    logic [31:0] host_id;
    logic [15:0] tx_seq;
    logic        last;
  } result_t;

endpackage

>>> rtl/mlff_if.sv
// mlff_if: valid/ready channel interfaces for input items and result items
// depends on nothing; used by the top level ports
interface mlff_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] side;
  logic [7:0] rx_byte;

  modport source (output valid, func, side, rx_byte, input ready);
  modport sink (input valid, func, side, rx_byte, output ready);
endinterface

interface mlff_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  event_side;
  logic [31:0] sender_id;
  logic [15:0] frame_seq;
  logic [7:0]  payload_len;
  logic [5:0]  forward_mask;
  logic        newly_connected;
  logic [1:0]  role;
  logic [31:0] host_id;
  logic [15:0] tx_seq;
  logic        last;

  modport source (output valid, kind, event_side, sender_id, frame_seq, payload_len,
                  forward_mask, newly_connected, role, host_id, tx_seq, last,
                  input ready);
  modport sink (input valid, kind, event_side, sender_id, frame_seq, payload_len,
                forward_mask, newly_connected, role, host_id, tx_seq, last,
                output ready);
endinterface

>>> rtl/mlff_ram.sv
// mlff_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module mlff_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mesh_link_frame_filter_unit.sv
// mesh_link_frame_filter_unit: per side framing, duplicate window, link supervision
// depends on mlff_pkg, mlff_in_if / mlff_out_if and mlff_ram
//
// channel | dir | handshake           | contents
// in_ch   | in  | valid/ready         | func, side, rx_byte
// out_ch  | out | valid/ready         | kind .. tx_seq, last (zero to SIDES + 1 per input)
// cfg_*   | in  | cfg_we, no back-off | cfg_index selects register, cfg_wdata
//
// a byte that does not finish a frame is taken while the sequencer stays idle
// a finished frame scans the filled window ram entries one entry a cycle; a heartbeat
//   that brings a link up then runs a host election over all SIDES links
// a tick checks every link at once; each timed-out link is cleared, reruns the host
//   election and emits a timeout result, and a due heartbeat is reported last
// synchronous active-low reset; the window ram needs no clearing, only filled entries are read
// results sit in an output register so input is taken again while a result waits
module mesh_link_frame_filter_unit
  import mlff_pkg::*;
#(
  parameter int SIDES  = 6,
  parameter int WINDOW = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  mlff_in_if.sink     in_ch,
  mlff_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int SW = (SIDES > 1) ? $clog2(SIDES) : 1;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);

  // configuration
  logic [31:0] my_id_r;
  logic [15:0] timeout_r;
  logic [15:0] period_r;
  logic [7:0]  hb_tag_r;
  logic [7:0]  cmd_tag_r;

  // per side state
  logic [8:0]  rx_count_r [SIDES];
  logic [63:0] rx_hdr_r   [SIDES];
  logic        up_r       [SIDES];
  logic [31:0] id_r       [SIDES];
  logic [31:0] heard_r    [SIDES];

  // global state
  state_t      state_r, state_nxt;
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [31:0] now_r;
  logic [31:0] last_send_r;
  logic [15:0] send_seq_r;
  role_t       role_r;
  logic [31:0] host_r;

  // frame under work
  logic [2:0]  f_side_r;
  logic [7:0]  f_tag_r;
  logic [7:0]  f_len_r;
  logic [31:0] f_sender_r;
  logic [15:0] f_seq_r;
  logic [2:0]  f_kind_r;
  logic        f_newc_r;

  // tick scan
  logic [SIDES-1:0] tmask_r;
  logic        hbdue_r;
  logic [SW-1:0] t_idx_r;
  logic [31:0] gone_r;

  // host election
  logic [SW-1:0] e_idx_r;
  logic        e_any_r;
  logic [31:0] e_best_r;
  logic        e_tick_r;

  // window search
  logic [FW-1:0] s_idx_r;
  logic        s_cmp_r;

  // output register
  logic        out_v_r;
  result_t     out_r;

  // window ram
  logic          win_we;
  logic [AW-1:0] win_waddr, win_raddr;
  logic [47:0]   win_rdata;
  logic [FW:0]   rd_sum, wr_sum;

  mlff_ram #(.WIDTH(48), .DEPTH(WINDOW)) u_win (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata ({f_sender_r, f_seq_r}),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // ring positions wrap with one subtract, the sum stays below twice the depth
  assign rd_sum = (FW+1)'(head_r) + (FW+1)'(s_idx_r);
  assign wr_sum = (FW+1)'(head_r) + (FW+1)'(fill_r);
  assign win_raddr = (rd_sum >= (FW+1)'(WINDOW)) ? AW'(rd_sum - (FW+1)'(WINDOW)) : AW'(rd_sum);

  logic win_full;
  assign win_full  = (fill_r == FW'(WINDOW));
  assign win_waddr = win_full ? head_r :
                     ((wr_sum >= (FW+1)'(WINDOW)) ? AW'(wr_sum - (FW+1)'(WINDOW))
                                                  : AW'(wr_sum));

  // byte intake
  logic          in_xfer, side_ok;
  logic [SW-1:0] in_sidx;
  logic [63:0]   hdr_new;
  logic [8:0]    cnt_new;
  logic          frame_done;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign side_ok = ({1'b0, in_ch.side} < 4'(SIDES));
  assign in_sidx = in_ch.side[SW-1:0];
  assign hdr_new = (rx_count_r[in_sidx] < HEADER_BYTES)
                   ? {rx_hdr_r[in_sidx][55:0], in_ch.rx_byte} : rx_hdr_r[in_sidx];
  assign cnt_new = rx_count_r[in_sidx] + 9'd1;
  // header complete and payload length reached
  assign frame_done = (cnt_new >= HEADER_BYTES) &&
                      (cnt_new >= HEADER_BYTES + {1'b0, hdr_new[55:48]});

  // frame side as an array index
  logic [SW-1:0] f_sidx;
  assign f_sidx = f_side_r[SW-1:0];

  // tick compares, all links at once against the advanced time
  logic [SIDES-1:0] tm_c;
  logic             hb_c;
  always_comb begin
    for (int i = 0; i < SIDES; i++) begin
      tm_c[i] = up_r[i] && ((now_r - heard_r[i]) > {16'd0, timeout_r});
    end
    hb_c = (now_r - last_send_r) > {16'd0, period_r};
  end

  // more results to come after the current timeout
  logic t_later;
  always_comb begin
    t_later = hbdue_r;
    for (int j = 0; j < SIDES; j++) begin
      if (SW'(j) > t_idx_r && tmask_r[j]) t_later = 1'b1;
    end
  end

  // connected sides other than the frame side
  logic [5:0] fwd_c;
  for (genvar g = 0; g < 6; g++) begin : g_fwd
    if (g < SIDES) begin : g_on
      assign fwd_c[g] = up_r[g] && (f_side_r != 3'(g));
    end else begin : g_off
      assign fwd_c[g] = 1'b0;
    end
  end

  // search compare
  logic s_hit;
  assign s_hit = s_cmp_r && (win_rdata == {f_sender_r, f_seq_r});

  logic can_load;
  assign can_load = !out_v_r || out_ch.ready;

  logic tag_hb, tag_cmd;
  assign tag_hb  = (f_tag_r == hb_tag_r);
  assign tag_cmd = (f_tag_r == cmd_tag_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.func) state_nxt = ST_TEVAL;
          else if (side_ok && frame_done) state_nxt = ST_SEARCH;
        end
      end
      ST_TEVAL: state_nxt = (tm_c != '0) ? ST_TSCAN : ST_THB;
      ST_TSCAN: begin
        if (tmask_r[t_idx_r]) state_nxt = ST_ELECT;
        else if (t_idx_r == SW'(SIDES - 1)) state_nxt = ST_THB;
      end
      ST_TEMIT: begin
        if (can_load) state_nxt = (t_idx_r == SW'(SIDES - 1)) ? ST_THB : ST_TSCAN;
      end
      ST_THB: begin
        if (!hbdue_r || can_load) state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (s_hit) state_nxt = ST_FEMIT;
        else if (s_idx_r >= fill_r && !s_cmp_r) state_nxt = ST_INSERT;
      end
      ST_INSERT: state_nxt = (tag_hb && !up_r[f_sidx]) ? ST_ELECT : ST_FEMIT;
      ST_ELECT: begin
        if (e_idx_r == SW'(SIDES - 1)) state_nxt = ST_EAPPLY;
      end
      ST_EAPPLY: state_nxt = e_tick_r ? ST_TEMIT : ST_FEMIT;
      ST_FEMIT: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic    load_out;
  result_t res_c;
  always_comb begin
    in_ch.ready = 1'b0;
    win_we      = 1'b0;
    load_out    = 1'b0;
    res_c       = '0;
    res_c.role    = role_r;
    res_c.host_id = host_r;
    unique case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_INSERT: win_we = 1'b1;
      ST_TEMIT: begin
        load_out         = can_load;
        res_c.kind       = KIND_TIMEOUT;
        res_c.event_side = 3'(t_idx_r);
        res_c.sender_id  = gone_r;
        res_c.last       = !t_later;
      end
      ST_THB: begin
        load_out     = hbdue_r && can_load;
        res_c.kind   = KIND_HB_DUE;
        res_c.tx_seq = send_seq_r + 16'd1;
        res_c.last   = 1'b1;
      end
      ST_FEMIT: begin
        load_out              = can_load;
        res_c.kind            = f_kind_r;
        res_c.event_side      = f_side_r;
        res_c.sender_id       = f_sender_r;
        res_c.frame_seq       = f_seq_r;
        res_c.payload_len     = f_len_r;
        res_c.forward_mask    = (f_kind_r == KIND_HEARTBEAT || f_kind_r == KIND_COMMAND)
                                ? fwd_c : 6'd0;
        res_c.newly_connected = f_newc_r;
        res_c.last            = 1'b1;
      end
      default: ;
    endcase
  end

  // header shift registers, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_xfer && !in_ch.func && side_ok) begin
      rx_hdr_r[in_sidx] <= hdr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      my_id_r     <= '0;
      timeout_r   <= TIMEOUT_RESET;
      period_r    <= HB_PERIOD_RESET;
      hb_tag_r    <= HB_TAG_RESET;
      cmd_tag_r   <= CMD_TAG_RESET;
      head_r      <= '0;
      fill_r      <= '0;
      now_r       <= '0;
      last_send_r <= '0;
      send_seq_r  <= '0;
      role_r      <= NODE_UNASSIGNED;
      host_r      <= '0;
      out_v_r     <= 1'b0;
      s_cmp_r     <= 1'b0;
      for (int i = 0; i < SIDES; i++) begin
        rx_count_r[i] <= '0;
        up_r[i]       <= 1'b0;
        id_r[i]       <= '0;
        heard_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_MY_ID:     my_id_r   <= cfg_wdata;
          REG_TIMEOUT:   timeout_r <= cfg_wdata[15:0];
          REG_HB_PERIOD: period_r  <= cfg_wdata[15:0];
          REG_HB_TAG:    hb_tag_r  <= cfg_wdata[7:0];
          REG_CMD_TAG:   cmd_tag_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_v_r <= 1'b1;
        out_r   <= res_c;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.func) begin
              now_r <= now_r + 32'd1;
            end else if (side_ok) begin
              if (frame_done) begin
                rx_count_r[in_sidx] <= '0;
                f_side_r   <= in_ch.side;
                f_tag_r    <= hdr_new[63:56];
                f_len_r    <= hdr_new[55:48];
                f_sender_r <= hdr_new[47:16];
                f_seq_r    <= hdr_new[15:0];
                f_newc_r   <= 1'b0;
                s_idx_r    <= '0;
                s_cmp_r    <= 1'b0;
              end else begin
                rx_count_r[in_sidx] <= cnt_new;
              end
            end
          end
        end
        ST_TEVAL: begin
          tmask_r <= tm_c;
          hbdue_r <= hb_c;
          t_idx_r <= '0;
        end
        ST_TSCAN: begin
          if (tmask_r[t_idx_r]) begin
            gone_r           <= id_r[t_idx_r];
            up_r[t_idx_r]    <= 1'b0;
            id_r[t_idx_r]    <= '0;
            heard_r[t_idx_r] <= '0;
            e_idx_r  <= '0;
            e_any_r  <= 1'b0;
            e_best_r <= my_id_r;
            e_tick_r <= 1'b1;
          end else if (t_idx_r != SW'(SIDES - 1)) begin
            t_idx_r <= t_idx_r + SW'(1);
          end
        end
        ST_TEMIT: begin
          if (can_load && t_idx_r != SW'(SIDES - 1)) t_idx_r <= t_idx_r + SW'(1);
        end
        ST_THB: begin
          if (hbdue_r && can_load) begin
            send_seq_r  <= send_seq_r + 16'd1;
            last_send_r <= now_r;
          end
        end
        ST_SEARCH: begin
          // issue one read a cycle, compare the entry read the cycle before
          if (s_hit) begin
            f_kind_r <= KIND_DUPLICATE;
          end else if (s_idx_r < fill_r) begin
            s_idx_r <= s_idx_r + FW'(1);
            s_cmp_r <= 1'b1;
          end else begin
            s_cmp_r <= 1'b0;
          end
        end
        ST_INSERT: begin
          if (win_full) begin
            head_r <= (head_r == AW'(WINDOW - 1)) ? '0 : head_r + AW'(1);
          end else begin
            fill_r <= fill_r + FW'(1);
          end
          if (tag_hb) begin
            f_kind_r        <= KIND_HEARTBEAT;
            f_newc_r        <= !up_r[f_sidx];
            heard_r[f_sidx] <= now_r;
            id_r[f_sidx]    <= f_sender_r;
            up_r[f_sidx]    <= 1'b1;
            e_idx_r  <= '0;
            e_any_r  <= 1'b0;
            e_best_r <= my_id_r;
            e_tick_r <= 1'b0;
          end else if (tag_cmd) begin
            f_kind_r <= KIND_COMMAND;
          end else begin
            f_kind_r <= KIND_UNKNOWN;
          end
        end
        ST_ELECT: begin
          // running maximum over the connected neighbors
          if (up_r[e_idx_r]) begin
            e_any_r <= 1'b1;
            if (id_r[e_idx_r] > e_best_r) e_best_r <= id_r[e_idx_r];
          end
          if (e_idx_r != SW'(SIDES - 1)) e_idx_r <= e_idx_r + SW'(1);
        end
        ST_EAPPLY: begin
          if (!e_any_r) begin
            role_r <= NODE_UNASSIGNED;
            host_r <= '0;
          end else if (e_best_r == my_id_r && role_r != NODE_HOST) begin
            role_r <= NODE_HOST;
            host_r <= my_id_r;
          end else if (role_r != NODE_CLIENT || host_r != e_best_r) begin
            // a node already host that stays highest drops to client of itself
            role_r <= NODE_CLIENT;
            host_r <= e_best_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.kind            = out_r.kind;
  assign out_ch.event_side      = out_r.event_side;
  assign out_ch.sender_id       = out_r.sender_id;
  assign out_ch.frame_seq       = out_r.frame_seq;
  assign out_ch.payload_len     = out_r.payload_len;
  assign out_ch.forward_mask    = out_r.forward_mask;
  assign out_ch.newly_connected = out_r.newly_connected;
  assign out_ch.role            = out_r.role;
  assign out_ch.host_id         = out_r.host_id;
  assign out_ch.tx_seq          = out_r.tx_seq;
  assign out_ch.last            = out_r.last;

  // window never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW))
    else $error("window fill above depth");

  // the oldest entry only moves once the window is full
  a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != '0) |-> (fill_r == FW'(WINDOW)))
    else $error("window head moved before full");

  // search never reads past the filled entries
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (s_idx_r <= fill_r))
    else $error("window search past fill");

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for mesh_link_frame_filter_unit, with its own frame filter predictor
// depends on rtl/mlff_pkg.sv, rtl/mlff_if.sv and rtl/mesh_link_frame_filter_unit.sv
`timescale 1ns / 100ps

module tb_top;
  import mlff_pkg::*;

  localparam int SIDES      = 6;
  localparam int WINDOW     = 128;
  localparam int IDLE_WAIT  = 400;    // covers a full window scan plus host election
  localparam int HOLD_LEN   = 400;    // long receiver back-pressure stretch
  localparam int STALL_MAX  = 20000;  // watchdog: cycles without any transfer

  typedef struct {
    bit       func;
    bit [2:0] side;
    bit [7:0] rx_byte;
  } rx_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  mlff_in_if  in_ch ();
  mlff_out_if out_ch ();

  mesh_link_frame_filter_unit #(.SIDES(SIDES), .WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // stimulus and expectation stores
  rx_item_t rx_items[$];
  result_t  pending_results[$];

  // bench-side copy of the configuration registers
  bit [31:0] c_my_id;
  bit [15:0] c_timeout;
  bit [15:0] c_period;
  bit [7:0]  c_hb_tag;
  bit [7:0]  c_cmd_tag;

  // bench-side copy of the filter state
  int        rx_cnt   [SIDES];
  bit [63:0] rx_hdr   [SIDES];
  bit        lk_up    [SIDES];
  bit [31:0] lk_id    [SIDES];
  bit [31:0] lk_heard [SIDES];
  bit [31:0] win_snd  [WINDOW];
  bit [15:0] win_seq  [WINDOW];
  int        win_head;
  int        win_fill;
  bit [31:0] now_ms;
  bit [31:0] last_send;
  bit [15:0] send_seq;
  role_t     my_role;
  bit [31:0] host_reg;

  // bookkeeping
  int  errors;
  int  n_pushed;
  int  n_accepted;
  int  n_checked;
  int  n_frames;
  int  n_ticks;
  int  idle_cnt;
  int  stall_cnt;
  int  hold_left;
  int  quiet_cycles;
  bit  in_taken;
  bit  idle_en;
  bit  hold_start;
  bit  hold_used;

  // ---------------------------------------------------------------- predictor

  function automatic void add_result(logic [2:0] kind, logic [2:0] side, logic [31:0] snd,
                                     logic [15:0] sq, logic [7:0] plen, logic [5:0] fwd,
                                     logic newc, logic [15:0] txs);
    result_t r;
    r.kind            = kind;
    r.event_side      = side;
    r.sender_id       = snd;
    r.frame_seq       = sq;
    r.payload_len     = plen;
    r.forward_mask    = fwd;
    r.newly_connected = newc;
    r.role            = my_role;
    r.host_id         = host_reg;
    r.tx_seq          = txs;
    r.last            = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  // highest id among live links and our own wins; a sitting host that is
  // still highest drops to client of itself
  function automatic void elect_host();
    bit        any;
    bit [31:0] best;
    any  = 1'b0;
    best = c_my_id;
    for (int i = 0; i < SIDES; i++) begin
      if (lk_up[i]) begin
        any = 1'b1;
        if (lk_id[i] > best) best = lk_id[i];
      end
    end
    if (!any) begin
      my_role  = NODE_UNASSIGNED;
      host_reg = '0;
    end else if (best == c_my_id && my_role != NODE_HOST) begin
      my_role  = NODE_HOST;
      host_reg = c_my_id;
    end else if (my_role != NODE_CLIENT || host_reg != best) begin
      my_role  = NODE_CLIENT;
      host_reg = best;
    end
  endfunction

  // fifo window of recent pairs: hit reports a duplicate, miss inserts
  function automatic bit seen_before(bit [31:0] snd, bit [15:0] sq);
    int p;
    for (int i = 0; i < win_fill; i++) begin
      p = (win_head + i) % WINDOW;
      if (win_snd[p] == snd && win_seq[p] == sq) return 1'b1;
    end
    if (win_fill < WINDOW) begin
      p = (win_head + win_fill) % WINDOW;
      win_snd[p] = snd;
      win_seq[p] = sq;
      win_fill++;
    end else begin
      win_snd[win_head] = snd;
      win_seq[win_head] = sq;
      win_head = (win_head + 1) % WINDOW;
    end
    return 1'b0;
  endfunction

  function automatic bit [5:0] fwd_mask(int from);
    bit [5:0] m;
    m = '0;
    for (int i = 0; i < SIDES; i++)
      if (i != from && lk_up[i]) m[i] = 1'b1;
    return m;
  endfunction

  function automatic void filter_step(bit f, bit [2:0] s, bit [7:0] b);
    int        n0;
    int        si;
    bit [7:0]  tag;
    bit [7:0]  plen;
    bit [31:0] snd;
    bit [15:0] sq;
    bit [31:0] gone;
    bit        was;
    n0 = pending_results.size();
    if (!f) begin
      // bytes on sides past the last link are dropped
      if (int'(s) < SIDES) begin
        si = int'(s);
        if (rx_cnt[si] < 8) rx_hdr[si] = {rx_hdr[si][55:0], b};
        rx_cnt[si]++;
        if (rx_cnt[si] >= 8) begin
          tag  = rx_hdr[si][63:56];
          plen = rx_hdr[si][55:48];
          if (rx_cnt[si] >= 8 + int'(plen)) begin
            rx_cnt[si] = 0;
            snd = rx_hdr[si][47:16];
            sq  = rx_hdr[si][15:0];
            if (seen_before(snd, sq)) begin
              add_result(KIND_DUPLICATE, s, snd, sq, plen, '0, 1'b0, '0);
            end else if (tag == c_hb_tag) begin
              // heartbeat wins when both tags are equal
              was          = lk_up[si];
              lk_heard[si] = now_ms;
              lk_id[si]    = snd;
              lk_up[si]    = 1'b1;
              if (!was) elect_host();
              add_result(KIND_HEARTBEAT, s, snd, sq, plen, fwd_mask(si), !was, '0);
            end else if (tag == c_cmd_tag) begin
              add_result(KIND_COMMAND, s, snd, sq, plen, fwd_mask(si), 1'b0, '0);
            end else begin
              add_result(KIND_UNKNOWN, s, snd, sq, plen, '0, 1'b0, '0);
            end
          end
        end
      end
    end else begin
      now_ms++;
      for (int i = 0; i < SIDES; i++) begin
        if (lk_up[i] && (now_ms - lk_heard[i]) > {16'd0, c_timeout}) begin
          gone        = lk_id[i];
          lk_up[i]    = 1'b0;
          lk_id[i]    = '0;
          lk_heard[i] = '0;
          elect_host();
          add_result(KIND_TIMEOUT, i[2:0], gone, '0, '0, '0, 1'b0, '0);
        end
      end
      if ((now_ms - last_send) > {16'd0, c_period}) begin
        send_seq++;
        last_send = now_ms;
        add_result(KIND_HB_DUE, '0, '0, '0, '0, '0, 1'b0, send_seq);
      end
    end
    if (pending_results.size() > n0)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result kind", got.kind, '0);
      return;
    end
    want = pending_results[0];
    pending_results.delete(0);
    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.event_side != want.event_side)
      report_mismatch("event_side", got.event_side, want.event_side);
    if (got.sender_id != want.sender_id)
      report_mismatch("sender_id", got.sender_id, want.sender_id);
    if (got.frame_seq != want.frame_seq)
      report_mismatch("frame_seq", got.frame_seq, want.frame_seq);
    if (got.payload_len != want.payload_len)
      report_mismatch("payload_len", got.payload_len, want.payload_len);
    if (got.forward_mask != want.forward_mask)
      report_mismatch("forward_mask", got.forward_mask, want.forward_mask);
    if (got.newly_connected != want.newly_connected)
      report_mismatch("newly_connected", got.newly_connected, want.newly_connected);
    if (got.role != want.role) report_mismatch("role", got.role, want.role);
    if (got.host_id != want.host_id) report_mismatch("host_id", got.host_id, want.host_id);
    if (got.tx_seq != want.tx_seq) report_mismatch("tx_seq", got.tx_seq, want.tx_seq);
    if (got.last != want.last) report_mismatch("last", got.last, want.last);
    n_checked++;
  endtask

  // sample both channels at the rising edge; prediction on input transfer
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        filter_step(in_ch.func, in_ch.side, in_ch.rx_byte);
        in_taken = 1'b1;
        n_accepted++;
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind            = out_ch.kind;
        got.event_side      = out_ch.event_side;
        got.sender_id       = out_ch.sender_id;
        got.frame_seq       = out_ch.frame_seq;
        got.payload_len     = out_ch.payload_len;
        got.forward_mask    = out_ch.forward_mask;
        got.newly_connected = out_ch.newly_connected;
        got.role            = out_ch.role;
        got.host_id         = out_ch.host_id;
        got.tx_seq          = out_ch.tx_seq;
        got.last            = out_ch.last;
        check_result(got);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- driver

  // sender: new item at the falling edge once the previous one is taken
  always @(negedge clk) begin
    rx_item_t it;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      in_taken = 1'b0;
      if (idle_cnt > 0) begin
        idle_cnt--;
        in_ch.valid <= 1'b0;
      end else if (rx_items.size() > 0) begin
        it = rx_items[0];
        rx_items.delete(0);
        in_ch.func    <= it.func;
        in_ch.side    <= it.side;
        in_ch.rx_byte <= it.rx_byte;
        in_ch.valid   <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) idle_cnt = $urandom_range(1, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_start && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) stall_cnt = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(bit f, bit [2:0] s, bit [7:0] b);
    rx_item_t it;
    it.func    = f;
    it.side    = s;
    it.rx_byte = b;
    rx_items = {rx_items, it};
    n_pushed++;
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++) push_item(1'b1, 3'($urandom_range(0, 7)), 8'($urandom));
    n_ticks += n;
  endtask

  // header is tag, length, sender big endian, sequence big endian, then payload
  task automatic push_frame(bit [2:0] s, bit [7:0] tag, bit [7:0] plen, bit [31:0] snd,
                            bit [15:0] sq);
    push_item(1'b0, s, tag);
    push_item(1'b0, s, plen);
    for (int i = 3; i >= 0; i--) push_item(1'b0, s, snd[i*8 +: 8]);
    push_item(1'b0, s, sq[15:8]);
    push_item(1'b0, s, sq[7:0]);
    for (int i = 0; i < int'(plen); i++) push_item(1'b0, s, 8'($urandom));
    n_frames++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MY_ID:     c_my_id   = val;
      REG_TIMEOUT:   c_timeout = val[15:0];
      REG_HB_PERIOD: c_period  = val[15:0];
      REG_HB_TAG:    c_hb_tag  = val[7:0];
      REG_CMD_TAG:   c_cmd_tag = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(bit [31:0] id, bit [15:0] tmo, bit [15:0] per, bit [7:0] hbt,
                            bit [7:0] cmt);
    write_reg(REG_MY_ID, id);
    write_reg(REG_TIMEOUT, {16'd0, tmo});
    write_reg(REG_HB_PERIOD, {16'd0, per});
    write_reg(REG_HB_TAG, {24'd0, hbt});
    write_reg(REG_CMD_TAG, {24'd0, cmt});
  endtask

  // sender pauses until every expected result is back, then lets a dropped
  // partial frame or an ignored byte drain before any register write
  task automatic drain();
    while (rx_items.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // mostly well-formed frames with random content, some ticks, some noise
  task automatic random_traffic(int target);
    int        start;
    int        pick;
    bit [7:0]  tag;
    bit [31:0] senders[4];
    senders[0] = c_my_id + 32'd1;
    senders[1] = c_my_id - 32'd1;
    senders[2] = $urandom;
    senders[3] = 32'hFFFF_FFFF;
    start = n_pushed;
    while (n_pushed - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 3))
          0, 1:    tag = c_hb_tag;
          2:       tag = c_cmd_tag;
          default: tag = 8'($urandom);
        endcase
        push_frame(3'($urandom_range(0, SIDES - 1)), tag, 8'($urandom_range(0, 3)),
                   senders[$urandom_range(0, 3)], 16'($urandom_range(0, 7)));
      end else if (pick < 92) begin
        push_ticks($urandom_range(1, 5));
      end else if (pick < 97) begin
        push_item(1'b0, 3'($urandom_range(SIDES, 7)), 8'($urandom));
      end else begin
        // stray byte that knocks a side's framing out of step
        push_item(1'b0, 3'($urandom_range(0, SIDES - 1)), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = 1'b0;
    in_ch.side   = '0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    errors = 0; n_pushed = 0; n_accepted = 0; n_checked = 0; n_frames = 0; n_ticks = 0;
    idle_cnt = 0; stall_cnt = 0; hold_left = 0; quiet_cycles = 0;
    in_taken = 1'b0; idle_en = 1'b1; hold_start = 1'b0; hold_used = 1'b0;

    // predictor starts from the reset state
    c_my_id = '0; c_timeout = TIMEOUT_RESET; c_period = HB_PERIOD_RESET;
    c_hb_tag = HB_TAG_RESET; c_cmd_tag = CMD_TAG_RESET;
    for (int i = 0; i < SIDES; i++) begin
      rx_cnt[i] = 0; rx_hdr[i] = '0; lk_up[i] = 1'b0; lk_id[i] = '0; lk_heard[i] = '0;
    end
    win_head = 0; win_fill = 0; now_ms = '0; last_send = '0; send_seq = '0;
    my_role = NODE_UNASSIGNED; host_reg = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every kind, ignored sides, timeout and heartbeat due
    set_config(32'h8000_0000, 16'd3, 16'd2, 8'hA5, 8'h3C);
    push_frame(3'd0, 8'hA5, 8'd0, 32'h9000_0000, 16'h0001);
    push_frame(3'd5, 8'hA5, 8'd1, 32'h0000_0001, 16'hFFFF);
    push_frame(3'd1, 8'h3C, 8'd2, 32'hFFFF_FFFF, 16'h0000);
    push_frame(3'd2, 8'h3C, 8'd0, 32'hFFFF_FFFF, 16'h0000);  // duplicate pair
    push_frame(3'd3, 8'hFF, 8'd0, 32'h0000_0000, 16'h1234);  // unknown tag
    push_item(1'b0, 3'd6, 8'h00);
    push_item(1'b0, 3'd7, 8'hFF);
    push_ticks(6);
    drain();

    // equal tags, highest own id, zero timeout and period: host, then client
    // of itself, then both links time out on the next tick
    set_config(32'hFFFF_FFFF, 16'd0, 16'd0, 8'h00, 8'h00);
    push_frame(3'd2, 8'h00, 8'd0, 32'd5, 16'd10);
    push_frame(3'd3, 8'h00, 8'd0, 32'd7, 16'd11);
    push_ticks(2);
    drain();

    // random traffic with one long receiver hold-off so the input backs up
    set_config($urandom, 16'($urandom_range(2, 40)), 16'($urandom_range(1, 20)),
               8'($urandom), 8'($urandom));
    hold_start = 1'b1;
    random_traffic(55);
    drain();

    // final stretch at full rate on both sides
    set_config($urandom, 16'($urandom_range(1, 10)), 16'($urandom_range(0, 5)),
               8'h5A, 8'hA5);
    idle_en = 1'b0;
    random_traffic(30);
    drain();

    $display("covered %0d frames and %0d ticks over %0d accepted items", n_frames, n_ticks,
             n_accepted);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
